[rtl/rau_pkg.sv]
// Package for the rational arithmetic unit: widths, operation kinds, sequencer states.
// No dependencies.
package rau_pkg;
   localparam int OperandWidth = 16;
   localparam int ResultWidth  = 32;
   localparam int CountWidth   = $clog2(OperandWidth + 1);

   typedef logic [OperandWidth-1:0] operand_type;
   typedef logic [ResultWidth-1:0]  result_type;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_MUL    = 2'd1,
      KIND_CMP    = 2'd2,
      KIND_REDUCE = 2'd3
   } kind_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MUL1  = 8'b0000_0010,
      ST_MUL2  = 8'b0000_0100,
      ST_MUL3  = 8'b0000_1000,
      ST_GCD   = 8'b0001_0000,
      ST_DIVN  = 8'b0010_0000,
      ST_DIVD  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;
endpackage

[rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit top level: add, multiply, compare and reduce of fractions.
// Depends on rau_pkg.
//
// Usage:
//  - Request: drive req_kind and the four operands, raise start while busy is low.
//    The transaction is taken at that edge; busy rises the next cycle.
//  - Response: rsp_valid pulses for exactly one cycle with rsp_res_num, rsp_res_den,
//    rsp_equal and rsp_status. The receiver cannot stall; results must be taken then.
//  - Sequence: add/multiply/compare use one shared 16x16 multiplier in states MUL1,
//    MUL2 and MUL3, then present the result in DONE, where the strobe is up.
//    Reduce runs Euclid's loop on one shared restoring divider, one quotient bit
//    per cycle: each remainder step shifts OperandWidth bits and then tests the
//    remainder; after the loop come two more divisions for numerator and
//    denominator. Special cases of reduce (zero numerator, equal parts, zero
//    denominator) strobe in the cycle after acceptance.
//  - One transaction at a time: busy is high from acceptance through the strobe
//    cycle; the next transaction can be taken only once busy is low again.
//  - Reset: synchronous, active high; the sequencer returns to idle, no strobe.
//    Nothing is kept between transactions.
module rational_arithmetic_unit
   import rau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic signed [OperandWidth-1:0] req_a_num,
   input  logic signed [OperandWidth-1:0] req_a_den,
   input  logic signed [OperandWidth-1:0] req_b_num,
   input  logic signed [OperandWidth-1:0] req_b_den,
   output logic        rsp_valid,
   output logic signed [ResultWidth-1:0] rsp_res_num,
   output logic signed [ResultWidth-1:0] rsp_res_den,
   output logic        rsp_equal,
   output logic        rsp_status
);
   state_type state_ff, state_in;
   kind_type kind_ff;
   operand_type an_ff, ad_ff, bn_ff, bd_ff;
   result_type p0_ff, p1_ff, p0_in, p1_in;
   // gcd / divider working registers (magnitudes)
   operand_type x_ff, x_in, y_ff, y_in;      // Euclid pair, divisor is y
   operand_type quo_ff, quo_in;              // dividend shifting into quotient
   logic [OperandWidth:0] rem_ff, rem_in;    // partial remainder
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic div_run_ff, div_run_in;
   result_type rn_ff, rn_in, rd_ff, rd_in;
   logic eq_ff, eq_in, st_ff, st_in;

   logic accept;
   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // shared multiplier, full signed product
   operand_type mul_a, mul_b;
   logic signed [ResultWidth-1:0] mul_p;
   assign mul_p = $signed(mul_a) * $signed(mul_b);

   // shared divider step
   logic [OperandWidth:0] trial;
   logic [OperandWidth:0] shifted;
   logic                  fits;
   assign shifted = {rem_ff[OperandWidth-1:0], quo_ff[OperandWidth-1]};
   assign trial   = shifted - {1'b0, y_ff};
   assign fits    = !trial[OperandWidth];

   function automatic operand_type magn(operand_type v);
      magn = v[OperandWidth-1] ? operand_type'(-v) : v;
   endfunction

   // signed result from magnitude quotient, sign taken from original operand
   function automatic result_type apply_sign(operand_type q, logic neg);
      result_type w;
      w = {{(ResultWidth-OperandWidth){1'b0}}, q};
      apply_sign = neg ? result_type'(-w) : w;
   endfunction

   always_comb begin
      state_in   = state_ff;
      p0_in      = p0_ff;
      p1_in      = p1_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      div_run_in = div_run_ff;
      rn_in      = rn_ff;
      rd_in      = rd_ff;
      eq_in      = eq_ff;
      st_in      = st_ff;
      mul_a      = an_ff;
      mul_b      = bd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rn_in = '0;
               rd_in = '0;
               eq_in = 1'b0;
               st_in = 1'b0;
               if (kind_type'(req_kind) == KIND_REDUCE) begin
                  if (req_a_num == '0) begin
                     rd_in    = result_type'(req_a_den);
                     state_in = ST_DONE;
                  end else if (req_a_num == req_a_den) begin
                     rn_in    = result_type'(1);
                     rd_in    = result_type'(1);
                     state_in = ST_DONE;
                  end else if (req_a_den == '0) begin
                     rn_in    = result_type'(req_a_num);
                     st_in    = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     x_in       = magn(req_a_num);
                     y_in       = magn(req_a_den);
                     quo_in     = magn(req_a_num);
                     rem_in     = '0;
                     cnt_in     = CountWidth'(OperandWidth);
                     div_run_in = 1'b1;
                     state_in   = ST_GCD;
                  end
               end else begin
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            // an*bd (add, cmp) or an*bn (mul)
            mul_a = an_ff;
            mul_b = (kind_ff == KIND_MUL) ? bn_ff : bd_ff;
            p0_in = mul_p;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // ad*bn (add, cmp) or ad*bd (mul)
            mul_a = ad_ff;
            mul_b = (kind_ff == KIND_MUL) ? bd_ff : bn_ff;
            p1_in = mul_p;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
            case (kind_ff)
               KIND_ADD: begin
                  rn_in = p0_ff + p1_ff;
                  rd_in = mul_p;
               end
               KIND_MUL: begin
                  rn_in = p0_ff;
                  rd_in = p1_ff;
               end
               default: eq_in = (p0_ff == p1_ff);
            endcase
            state_in = ST_DONE;
         end
         ST_GCD, ST_DIVN, ST_DIVD: begin
            if (cnt_ff != '0) begin
               rem_in = fits ? trial : shifted;
               quo_in = {quo_ff[OperandWidth-2:0], fits};
               cnt_in = cnt_ff - 1'b1;
            end else if (state_ff == ST_GCD) begin
               // rem_ff holds x mod y
               if (rem_ff[OperandWidth-1:0] == '0) begin
                  // gcd is y: divide numerator magnitude next
                  x_in   = y_ff;
                  quo_in = magn(an_ff);
                  rem_in = '0;
                  cnt_in = CountWidth'(OperandWidth);
                  state_in = ST_DIVN;
               end else begin
                  x_in   = y_ff;
                  y_in   = rem_ff[OperandWidth-1:0];
                  quo_in = y_ff;
                  rem_in = '0;
                  cnt_in = CountWidth'(OperandWidth);
               end
            end else if (state_ff == ST_DIVN) begin
               rn_in  = apply_sign(quo_ff, an_ff[OperandWidth-1]);
               quo_in = magn(ad_ff);
               rem_in = '0;
               cnt_in = CountWidth'(OperandWidth);
               state_in = ST_DIVD;
            end else begin
               rd_in      = apply_sign(quo_ff, ad_ff[OperandWidth-1]);
               div_run_in = 1'b0;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            div_run_in = 1'b0;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_run_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         div_run_ff <= div_run_in;
      end
      if (accept) begin
         kind_ff <= kind_type'(req_kind);
         an_ff   <= req_a_num;
         ad_ff   <= req_a_den;
         bn_ff   <= req_b_num;
         bd_ff   <= req_b_den;
      end
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      rn_ff  <= rn_in;
      rd_ff  <= rd_in;
      eq_ff  <= eq_in;
      st_ff  <= st_in;
   end

   assign rsp_valid   = (state_ff == ST_DONE);
   assign rsp_res_num = rn_ff;
   assign rsp_res_den = rd_ff;
   assign rsp_equal   = eq_ff;
   assign rsp_status  = st_ff;

   // divider only runs in the gcd / division states (the check also allows done)
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_run_ff |-> (state_ff == ST_GCD || state_ff == ST_DIVN ||
                      state_ff == ST_DIVD || state_ff == ST_DONE))
      else $error("divider active outside reduce");
   // strobe lasts a single cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");
   // accepted transaction makes block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after accept");
   // euclid divisor never zero in the gcd loop
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD) |-> (y_ff != '0))
      else $error("zero divisor in gcd loop");
endmodule
